// ===== src/dhcpl_pkg.sv =====
// Shared types and constants for the DHCP option parser and lease block.
// Used by every module under src; depends on nothing.
package dhcpl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned MAC_W = 48;

  localparam logic [ADDR_W-3:0] REG_SERVER_IP = 2'd0;
  localparam logic [ADDR_W-3:0] REG_POOL_LOW  = 2'd1;
  localparam logic [ADDR_W-3:0] REG_POOL_HIGH = 2'd2;

  localparam logic [31:0] SERVER_IP_RESET = 32'hC0A8_A901;
  localparam logic [7:0]  POOL_LOW_RESET  = 8'd2;
  localparam logic [7:0]  POOL_HIGH_RESET = 8'd254;

  localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_REQ_IP   = 8'd50;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;

  localparam logic [7:0] TYPE_DISCOVER = 8'd1;
  localparam logic [7:0] TYPE_REQUEST  = 8'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_NAK   = 2'd1;
  localparam logic [1:0] KIND_OFFER = 2'd2;
  localparam logic [1:0] KIND_ACK   = 2'd3;

  localparam logic [2:0] CAPTURE_MAX = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] lease_ip;
    logic [7:0]  msg_type;
  } reply_t;

endpackage

// ===== src/dhcp_option_parse_and_lease.sv =====
// Top level of the DHCP option parser and lease block: input and result
// registers, configuration port. Depends on dhcpl_pkg, dhcpl_lease, dhcpl_parse.
//
//   Channel   Handshake                 Beat
//   input     in_valid / in_ready       first, client_mac, data
//   result    out_valid / out_ready     reply_kind, lease_ip, msg_type
//   config    psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// One byte a cycle sustained while the result is not held; a byte waits in the
// input register; its reply, if any, is registered in the result register.
// The lease lookup compares all table entries in parallel in the same cycle.
// A stalled result blocks further bytes only once the input register is full.
// Synchronous reset clears the lease table, parser, counters and valid flags.
module dhcp_option_parse_and_lease #(
  parameter int unsigned TABLE_ENTRIES = dhcpl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         first,
  input  logic [dhcpl_pkg::MAC_W-1:0]  client_mac,
  input  logic [7:0]                   data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   reply_kind,
  output logic [31:0]                  lease_ip,
  output logic [7:0]                   msg_type,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dhcpl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [31:0] server_ip;
  logic [7:0]  pool_low;
  logic [7:0]  pool_high;

  logic                        ir_valid;
  logic                        ir_first;
  logic [dhcpl_pkg::MAC_W-1:0] ir_mac;
  logic [7:0]                  ir_data;

  logic              advance;
  logic [7:0]        lease_host;
  dhcpl_pkg::reply_t reply;

  assign pready = 1'b1;
  assign advance = ir_valid && (!out_valid || out_ready);
  assign in_ready = !ir_valid || advance;

  always_comb begin
    case (paddr[dhcpl_pkg::ADDR_W-1:2])
      dhcpl_pkg::REG_SERVER_IP: prdata = server_ip;
      dhcpl_pkg::REG_POOL_LOW:  prdata = {24'd0, pool_low};
      dhcpl_pkg::REG_POOL_HIGH: prdata = {24'd0, pool_high};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_ip <= dhcpl_pkg::SERVER_IP_RESET;
      pool_low <= dhcpl_pkg::POOL_LOW_RESET;
      pool_high <= dhcpl_pkg::POOL_HIGH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[dhcpl_pkg::ADDR_W-1:2])
        dhcpl_pkg::REG_SERVER_IP: server_ip <= pwdata;
        dhcpl_pkg::REG_POOL_LOW:  pool_low <= pwdata[7:0];
        dhcpl_pkg::REG_POOL_HIGH: pool_high <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      ir_first <= first;
      ir_mac <= client_mac;
      ir_data <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (reply.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (reply.valid) begin
      reply_kind <= reply.kind;
      lease_ip <= reply.lease_ip;
      msg_type <= reply.msg_type;
    end
  end

  dhcpl_lease #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_lease (
    .clk       (clk),
    .rst       (rst),
    .step      (advance && ir_first),
    .mac       (ir_mac),
    .pool_low  (pool_low),
    .pool_high (pool_high),
    .host      (lease_host)
  );

  dhcpl_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .first      (ir_first),
    .data       (ir_data),
    .lease_host (lease_host),
    .server_ip  (server_ip),
    .reply      (reply)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    reply.valid |-> !out_valid || out_ready)
    else $error("Reply produced while the result register was held.");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    ir_valid && !advance |=> ir_valid && $stable(ir_data) && $stable(ir_first))
    else $error("Buffered byte lost while stalled.");

  a_reply_prefix: assert property (@(posedge clk) disable iff (rst)
    reply.valid |=> lease_ip[31:8] == $past(server_ip[31:8]))
    else $error("Client address prefix does not match the server address.");

endmodule

// ===== src/dhcpl_lease.sv =====
// Lease table: matches the client MAC and hands out host numbers round-robin.
// Depends on dhcpl_pkg.
module dhcpl_lease #(
  parameter int unsigned TABLE_ENTRIES = dhcpl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [dhcpl_pkg::MAC_W-1:0] mac,
  input  logic [7:0]                  pool_low,
  input  logic [7:0]                  pool_high,
  output logic [7:0]                  host
);

  localparam int unsigned SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);

  logic [dhcpl_pkg::MAC_W-1:0] lease_mac [TABLE_ENTRIES];
  logic [7:0]                  lease_host [TABLE_ENTRIES];
  logic [SLOT_W-1:0]           replace_slot;
  logic [7:0]                  next_host;

  logic       special;
  logic       hit;
  logic [7:0] hit_host;
  logic       allocate;

  always_comb begin
    special = (mac == '0) || (mac == dhcpl_pkg::MAC_ONES);
    hit = 1'b0;
    hit_host = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (lease_mac[i] == mac) begin
        hit = 1'b1;
        hit_host = lease_host[i];
      end
    end
    if (special) begin
      host = pool_high;
    end else if (hit) begin
      host = hit_host;
    end else begin
      host = next_host;
    end
    allocate = step && !special && !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        lease_mac[i] <= '0;
        lease_host[i] <= '0;
      end
      replace_slot <= '0;
      next_host <= dhcpl_pkg::POOL_LOW_RESET;
    end else if (allocate) begin
      lease_mac[replace_slot] <= mac;
      lease_host[replace_slot] <= next_host;
      replace_slot <= (replace_slot == SLOT_LAST) ? '0 : replace_slot + 1'b1;
      next_host <= (next_host >= pool_high) ? pool_low : next_host + 8'd1;
    end
  end

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    replace_slot <= SLOT_LAST)
    else $error("Replacement slot left the table.");

  a_alloc_advances: assert property (@(posedge clk) disable iff (rst)
    allocate && (TABLE_ENTRIES > 1) |=> replace_slot != $past(replace_slot))
    else $error("Replacement slot did not advance after a new lease.");

endmodule

// ===== src/dhcpl_parse.sv =====
// Option walker: tracks type-length-value position, captures the message type
// and requested IP, and forms the reply on END. Depends on dhcpl_pkg.
module dhcpl_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              first,
  input  logic [7:0]        data,
  input  logic [7:0]        lease_host,
  input  logic [31:0]       server_ip,
  output dhcpl_pkg::reply_t reply
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CODE,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t      phase, phase_next, phase_cur;
  logic [7:0]  current_code, current_code_next, code_cur;
  logic [7:0]  bytes_left, bytes_left_next, left_cur;
  logic [31:0] requested_addr, requested_addr_next, req_cur;
  logic [2:0]  capture_count, capture_count_next, count_cur;
  logic [7:0]  seen_type, seen_type_next, type_cur;
  logic [7:0]  assigned_host, assigned_host_next;
  logic [31:0] cip;

  always_comb begin
    if (first) begin
      phase_cur = PH_CODE;
      code_cur = '0;
      left_cur = '0;
      req_cur = '0;
      count_cur = '0;
      type_cur = '0;
      assigned_host_next = lease_host;
    end else begin
      phase_cur = phase;
      code_cur = current_code;
      left_cur = bytes_left;
      req_cur = requested_addr;
      count_cur = capture_count;
      type_cur = seen_type;
      assigned_host_next = assigned_host;
    end

    phase_next = phase_cur;
    current_code_next = code_cur;
    bytes_left_next = left_cur;
    requested_addr_next = req_cur;
    capture_count_next = count_cur;
    seen_type_next = type_cur;

    cip = {server_ip[31:8], assigned_host_next};
    reply.valid = 1'b0;
    reply.lease_ip = cip;
    reply.msg_type = type_cur;
    if ((req_cur != '0) && (req_cur != cip)) begin
      reply.kind = dhcpl_pkg::KIND_NAK;
    end else if (type_cur == dhcpl_pkg::TYPE_DISCOVER) begin
      reply.kind = dhcpl_pkg::KIND_OFFER;
    end else if (type_cur == dhcpl_pkg::TYPE_REQUEST) begin
      reply.kind = dhcpl_pkg::KIND_ACK;
    end else begin
      reply.kind = dhcpl_pkg::KIND_NONE;
    end

    case (phase_cur)
      PH_CODE: begin
        if (data == dhcpl_pkg::OPT_END) begin
          reply.valid = 1'b1;
          phase_next = PH_IDLE;
        end else if (data != dhcpl_pkg::OPT_PAD) begin
          current_code_next = data;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_left_next = data;
        capture_count_next = '0;
        if (code_cur == dhcpl_pkg::OPT_REQ_IP) begin
          requested_addr_next = '0;
        end
        phase_next = (data == '0) ? PH_CODE : PH_BODY;
      end
      PH_BODY: begin
        if ((code_cur == dhcpl_pkg::OPT_MSG_TYPE) && (count_cur == '0)) begin
          seen_type_next = data;
        end
        if ((code_cur == dhcpl_pkg::OPT_REQ_IP) && (count_cur < dhcpl_pkg::CAPTURE_MAX)) begin
          requested_addr_next = {req_cur[23:0], data};
        end
        if (count_cur < dhcpl_pkg::CAPTURE_MAX) begin
          capture_count_next = count_cur + 3'd1;
        end
        bytes_left_next = left_cur - 8'd1;
        if (bytes_left_next == '0) begin
          phase_next = PH_CODE;
        end
      end
      default: begin
      end
    endcase

    reply.valid = reply.valid && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      current_code <= '0;
      bytes_left <= '0;
      requested_addr <= '0;
      capture_count <= '0;
      seen_type <= '0;
      assigned_host <= '0;
    end else if (step) begin
      phase <= phase_next;
      current_code <= current_code_next;
      bytes_left <= bytes_left_next;
      requested_addr <= requested_addr_next;
      capture_count <= capture_count_next;
      seen_type <= seen_type_next;
      assigned_host <= assigned_host_next;
    end
  end

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    reply.valid |=> phase == PH_IDLE)
    else $error("Parser did not stop after END.");

  a_idle_ignores: assert property (@(posedge clk) disable iff (rst)
    step && !first && (phase == PH_IDLE) |-> !reply.valid)
    else $error("Reply given for a byte after END.");

  a_empty_option: assert property (@(posedge clk) disable iff (rst)
    step && !first && (phase == PH_LEN) && (data == '0) |=> phase == PH_CODE)
    else $error("Zero-length option did not return to the code position.");

  a_capture_bound: assert property (@(posedge clk) disable iff (rst)
    capture_count <= dhcpl_pkg::CAPTURE_MAX)
    else $error("Capture count passed four.");

endmodule
